@@ rtl/srr_pkg.sv @@
// Shared types and constants for the selective repeat receiver.
// Used by srr_ctrl, srr_dp and selective_repeat_receiver_top.
package srr_pkg;

  localparam int SEQ_BITS_DEF = 4;
  localparam int DATA_W       = 64;
  localparam int WIN_W        = 4;
  localparam int WIN_HARD_MAX = 8;
  localparam logic [WIN_W-1:0] WIN_RESET = 4'd8;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_DLV = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_DLV
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic emit_ack;
    logic emit_dlv;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic good_beat;
    logic out_free;
    logic pending;
    logic dlv_last;
  } status_t;

endpackage

@@ rtl/selective_repeat_receiver_top.sv @@
// Selective repeat receiver: one packet beat in, one ACK beat and up to one
// window of in-order delivery beats out. The ACK beat is loaded into the
// output register in the ACK state that follows acceptance, then one
// delivery beat per cycle while the output is not stalled; no new packet is
// accepted until the last beat of the packet has been loaded.
// Reset: window base 0, all marks cleared, window size 8; store not cleared.
module selective_repeat_receiver_top
  import srr_pkg::*;
#(
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [WIN_W-1:0]                          cfg_wdata,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // seq_num, payload; zero padded to whole bytes
  input  logic [((SEQ_BITS+DATA_W+7)/8)*8-1:0]      s_tdata,
  // checksum_ok
  input  logic                                      s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // ack_num, data; zero padded to whole bytes
  output logic [((SEQ_BITS+DATA_W+7)/8)*8-1:0]      m_tdata,
  // kind
  output logic                                      m_tuser,
  output logic                                      m_tlast
);

  localparam int TDATA_W = ((SEQ_BITS + DATA_W + 7) / 8) * 8;
  localparam int PAD_W   = TDATA_W - SEQ_BITS - DATA_W;

  cmd_t                cmd;
  status_t             status;
  logic                in_ready;
  logic [SEQ_BITS-1:0] out_ack;
  logic [DATA_W-1:0]   out_data;

  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  srr_dp #(
    .SEQ_BITS (SEQ_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_tvalid),
    .in_seq     (s_tdata[SEQ_BITS-1:0]),
    .in_ok      (s_tuser),
    .in_payload (s_tdata[SEQ_BITS+DATA_W-1:SEQ_BITS]),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_ack    (out_ack),
    .out_data   (out_data),
    .out_last   (m_tlast)
  );

  assign s_tready = in_ready;
  assign m_tdata  = {{PAD_W{1'b0}}, out_data, out_ack};

endmodule

@@ rtl/srr_ctrl.sv @@
// Sequencing state machine of the selective repeat receiver.
// Depends on srr_pkg; drives commands into srr_dp.
module srr_ctrl
  import srr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_ready
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // A corrupt beat is taken and dropped without leaving idle.
        if (status.good_beat) begin
          cmd.capture = 1'b1;
          state_next  = ST_ACK;
        end
      end
      ST_ACK: begin
        if (status.out_free) begin
          cmd.emit_ack = 1'b1;
          state_next   = status.pending ? ST_DLV : ST_IDLE;
        end
      end
      ST_DLV: begin
        if (status.out_free) begin
          cmd.emit_dlv = 1'b1;
          state_next   = status.dlv_last ? ST_IDLE : ST_DLV;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/srr_dp.sv @@
// Datapath of the selective repeat receiver: window base, received marks,
// payload store, window register and the output register. Depends on srr_pkg.
module srr_dp
  import srr_pkg::*;
#(
  parameter int SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [WIN_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  input  logic [SEQ_BITS-1:0] in_seq,
  input  logic                in_ok,
  input  logic [DATA_W-1:0]   in_payload,
  input  cmd_t                cmd,
  output status_t             status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [SEQ_BITS-1:0] out_ack,
  output logic [DATA_W-1:0]   out_data,
  output logic                out_last
);

  localparam int SEQ_SPACE = 2 ** SEQ_BITS;
  localparam int WIN_CAP_I = (SEQ_SPACE / 2 > WIN_HARD_MAX) ? WIN_HARD_MAX : SEQ_SPACE / 2;
  localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'(WIN_CAP_I);

  logic [WIN_W-1:0]     win_cfg;
  logic [WIN_W-1:0]     win;
  logic [SEQ_BITS-1:0]  base;
  logic [SEQ_BITS-1:0]  base_inc;
  logic [SEQ_BITS-1:0]  offset;
  logic                 hit;
  logic [SEQ_SPACE-1:0] flags;
  logic [DATA_W-1:0]    store [SEQ_SPACE];
  logic [DATA_W-1:0]    rdata;
  logic [SEQ_BITS-1:0]  rd_addr;
  logic [SEQ_BITS-1:0]  seq_q;
  logic                 hit_q;
  logic [WIN_W-1:0]     cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg <= WIN_RESET;
    end else if (cfg_we) begin
      win_cfg <= cfg_wdata;
    end
  end

  // Clamp the configured window into one to the cap.
  always_comb begin
    if (win_cfg == '0) begin
      win = WIN_W'(1);
    end else if (win_cfg > WIN_CAP) begin
      win = WIN_CAP;
    end else begin
      win = win_cfg;
    end
  end

  assign base_inc = base + SEQ_BITS'(1);
  assign offset   = in_seq - base;
  assign hit      = {{WIN_W{1'b0}}, offset} < {{SEQ_BITS{1'b0}}, win};

  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= '0;
      flags <= '0;
    end else if (cmd.capture && hit) begin
      flags[in_seq] <= 1'b1;
    end else if (cmd.emit_dlv) begin
      flags[base] <= 1'b0;
      base        <= base_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seq_q <= in_seq;
      hit_q <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.capture) begin
      cnt <= '0;
    end else if (cmd.emit_dlv) begin
      cnt <= cnt + WIN_W'(1);
    end
  end

  // The read port follows the base ahead by one step, so the word at the
  // current base is always ready in rdata during delivery.
  assign rd_addr = cmd.emit_dlv ? base_inc : base;

  always_ff @(posedge clk) begin
    if (cmd.capture && hit) begin
      store[in_seq] <= in_payload;
    end
    rdata <= store[rd_addr];
  end

  assign status.good_beat = in_valid && in_ok;
  assign status.out_free  = !out_valid || out_ready;
  assign status.pending   = hit_q && flags[base];
  assign status.dlv_last  = (cnt + WIN_W'(1) == win) || !flags[base_inc];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ack || cmd.emit_dlv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ack) begin
      out_kind <= KIND_ACK;
      out_ack  <= seq_q;
      out_data <= '0;
      out_last <= !status.pending;
    end else if (cmd.emit_dlv) begin
      out_kind <= KIND_DLV;
      out_ack  <= '0;
      out_data <= rdata;
      out_last <= status.dlv_last;
    end
  end

  a_dlv_marked: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_dlv |-> flags[base])
    else $error("delivery from an unmarked slot");

  a_dlv_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_dlv |-> (cnt < win))
    else $error("more than one window delivered for a packet");

  a_mark_set: assert property (@(posedge clk) disable iff (rst)
    (cmd.capture && hit) |=> flags[seq_q])
    else $error("accepted in-window packet not marked");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(cmd.emit_ack || cmd.emit_dlv))
    else $error("output register overwritten while stalled");

endmodule
